/* rtl/core/qte_pkg.sv */
// Shared types, widths and the arctangent table for the quaternion to Euler converter.
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_TAB_LEN      = 24;

	// Sine and cosine terms are Q.28 with headroom for non-unit inputs.
	localparam int TERM_W  = 36;
	localparam int MAG_W   = 28;
	localparam int REM_W   = 57;
	localparam int SQRT_W  = 29;
	localparam int VEC_W   = 38;
	localparam int ANG_W   = 26;
	localparam int RND_W   = ANG_W - 9;

	localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(90 * 65536);
	localparam logic signed [RND_W-1:0] HALF_LIM     = RND_W'(23040);
	localparam logic signed [RND_W-1:0] QUARTER_LIM  = RND_W'(11520);

	typedef struct packed {
		logic signed [TERM_W-1:0] rs;
		logic signed [TERM_W-1:0] rc;
		logic signed [TERM_W-1:0] ys;
		logic signed [TERM_W-1:0] yc;
		logic signed [TERM_W-1:0] ps;
		logic                     sat_pos;
		logic                     sat_neg;
	} terms_t;

	// atan(2^-i) in degrees, scaled by 65536 and rounded.
	function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
		logic signed [ANG_W-1:0] v;
		case (idx)
			0: v = ANG_W'(2949120);
			1: v = ANG_W'(1740967);
			2: v = ANG_W'(919879);
			3: v = ANG_W'(466945);
			4: v = ANG_W'(234379);
			5: v = ANG_W'(117304);
			6: v = ANG_W'(58666);
			7: v = ANG_W'(29335);
			8: v = ANG_W'(14668);
			9: v = ANG_W'(7334);
			10: v = ANG_W'(3667);
			11: v = ANG_W'(1833);
			12: v = ANG_W'(917);
			13: v = ANG_W'(458);
			14: v = ANG_W'(229);
			15: v = ANG_W'(115);
			16: v = ANG_W'(57);
			17: v = ANG_W'(29);
			18: v = ANG_W'(14);
			19: v = ANG_W'(7);
			20: v = ANG_W'(4);
			21: v = ANG_W'(2);
			22: v = ANG_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/qte_terms.sv */
// Product, sum and square stages that form the sine and cosine terms.
`timescale 1ns / 1ps
`default_nettype none
module qte_terms (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    en,
	input  wire                    in_valid,
	input  wire signed [15:0]      q_w,
	input  wire signed [15:0]      q_x,
	input  wire signed [15:0]      q_y,
	input  wire signed [15:0]      q_z,
	output logic                   out_valid,
	output qte_pkg::terms_t        terms,
	output logic [qte_pkg::REM_W-1:0] rem
);
	localparam int TW = qte_pkg::TERM_W;
	localparam int MW = qte_pkg::MAG_W;
	localparam int RW = qte_pkg::REM_W;

	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1, wy_s1, zx_s1;
	logic               valid_s1, valid_s2, valid_s3;
	qte_pkg::terms_t    terms_s2, terms_s3, terms_c;
	logic [MW-1:0]      mag_s2;
	logic [RW-1:0]      rem_s3;
	logic signed [TW-1:0] mag_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		terms_c.rs = TW'(2) * (TW'(wx_s1) + TW'(yz_s1));
		terms_c.rc = (TW'(1) <<< 28) - TW'(2) * (TW'(xx_s1) + TW'(yy_s1));
		terms_c.ys = TW'(2) * (TW'(wz_s1) + TW'(xy_s1));
		terms_c.yc = (TW'(1) <<< 28) - TW'(2) * (TW'(yy_s1) + TW'(zz_s1));
		terms_c.ps = TW'(2) * (TW'(wy_s1) - TW'(zx_s1));
		terms_c.sat_pos = (terms_c.ps >= (TW'(1) <<< 28));
		terms_c.sat_neg = (terms_c.ps <= -(TW'(1) <<< 28));
		mag_c = terms_c.ps[TW-1] ? -terms_c.ps : terms_c.ps;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= q_w * q_x;
			yz_s1 <= q_y * q_z;
			xx_s1 <= q_x * q_x;
			yy_s1 <= q_y * q_y;
			wz_s1 <= q_w * q_z;
			xy_s1 <= q_x * q_y;
			zz_s1 <= q_z * q_z;
			wy_s1 <= q_w * q_y;
			zx_s1 <= q_z * q_x;
			terms_s2 <= terms_c;
			mag_s2 <= mag_c[MW-1:0];
			terms_s3 <= terms_s2;
			// Only meaningful when the sine term is below one in magnitude.
			rem_s3 <= (RW'(1) << 56) - RW'(mag_s2) * RW'(mag_s2);
		end
	end

	assign out_valid = valid_s3;
	assign terms     = terms_s3;
	assign rem       = rem_s3;
endmodule
`default_nettype wire

/* rtl/core/qte_isqrt.sv */
// Pipelined integer square root, one result bit per stage, with a carried side word.
`timescale 1ns / 1ps
`default_nettype none
module qte_isqrt #(
	parameter int SIDE_W = 1
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire                          in_valid,
	input  wire [qte_pkg::REM_W-1:0]     rad,
	input  wire [SIDE_W-1:0]             side_in,
	output logic                         out_valid,
	output logic [qte_pkg::SQRT_W-1:0]   root,
	output logic [SIDE_W-1:0]            side_out
);
	localparam int RW = qte_pkg::REM_W;
	localparam int NB = qte_pkg::SQRT_W;
	localparam int SW = RW + 1;

	logic [RW-1:0]     op_s  [NB];
	logic [SW-1:0]     res_s [NB];
	logic [SIDE_W-1:0] side_s[NB];
	logic [NB-1:0]     vld_s;

	for (genvar j = 0; j < NB; j++) begin : g_bit
		localparam logic [SW-1:0] ONE = SW'(1) << (2 * (NB - 1 - j));
		logic [RW-1:0]     op_p;
		logic [SW-1:0]     res_p;
		logic [SIDE_W-1:0] side_p;
		logic              vld_p;
		logic [SW:0]       trial;
		logic              ge;

		if (j == 0) begin : g_first
			assign op_p   = rad;
			assign res_p  = '0;
			assign side_p = side_in;
			assign vld_p  = in_valid;
		end else begin : g_next
			assign op_p   = op_s[j-1];
			assign res_p  = res_s[j-1];
			assign side_p = side_s[j-1];
			assign vld_p  = vld_s[j-1];
		end

		assign trial = {1'b0, res_p} + {1'b0, ONE};
		assign ge    = {2'b00, op_p} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				op_s[j]   <= ge ? op_p - trial[RW-1:0] : op_p;
				res_s[j]  <= ge ? (res_p >> 1) + ONE : res_p >> 1;
				side_s[j] <= side_p;
			end
		end
	end

	assign out_valid = vld_s[NB-1];
	assign root      = res_s[NB-1][NB-1:0];
	assign side_out  = side_s[NB-1];
endmodule
`default_nettype wire

/* rtl/core/qte_cordic.sv */
// Pipelined vectoring CORDIC giving atan2 in 1/128 degree, before clamping.
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic #(
	parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                en,
	input  wire                                in_valid,
	input  wire signed [qte_pkg::VEC_W-1:0]    vy,
	input  wire signed [qte_pkg::VEC_W-1:0]    vx,
	output logic                               out_valid,
	output logic signed [qte_pkg::RND_W-1:0]   angle
);
	localparam int VW = qte_pkg::VEC_W;
	localparam int ZW = qte_pkg::ANG_W;
	localparam int N  = (CORDIC_STAGES < qte_pkg::ATAN_TAB_LEN) ?
	                    CORDIC_STAGES : qte_pkg::ATAN_TAB_LEN;

	logic signed [VW-1:0] x_s [N+1];
	logic signed [VW-1:0] y_s [N+1];
	logic signed [ZW-1:0] z_s [N+1];
	logic [N:0]           zero_s;
	logic [N:0]           vld_s;
	logic signed [ZW-1:0] zr;
	logic signed [qte_pkg::RND_W-1:0] angle_q;
	logic                 valid_q;

	// Entry stage: vectors in the left half plane are turned by a right angle first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (vx == '0) && (vy == '0);
			if (vx[VW-1] && !vy[VW-1]) begin
				x_s[0] <= vy;
				y_s[0] <= -vx;
				z_s[0] <= qte_pkg::QUARTER_TURN;
			end else if (vx[VW-1]) begin
				x_s[0] <= -vy;
				y_s[0] <= vx;
				z_s[0] <= -qte_pkg::QUARTER_TURN;
			end else begin
				x_s[0] <= vx;
				y_s[0] <= vy;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		localparam logic signed [ZW-1:0] ATN = qte_pkg::atan_entry(i);
		logic signed [VW-1:0] dx, dy;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (!y_s[i][VW-1]) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + ATN;
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - ATN;
				end
			end
		end
	end

	// Round to 1/128 degree with ties upward; the zero vector gives zero.
	assign zr = z_s[N] + ZW'(256);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_q <= zero_s[N] ? '0 : zr[ZW-1:9];
		end
	end

	assign out_valid = valid_q;
	assign angle     = angle_q;
endmodule
`default_nettype wire

/* rtl/core/quaternion_to_euler_degrees.sv */
// Top level of the quaternion to roll, pitch and yaw converter.
// Takes one Q1.14 quaternion per cycle and returns ZYX Euler angles in 1/128 degree.
// The pipeline has 3 term stages, 29 square root stages, min(CORDIC_STAGES,24)+2 CORDIC
// stages and one clamp stage. A request is taken in every cycle in which the output
// register is empty or being drained; the whole pipeline holds while a result waits.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_degrees #(
	parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [63:0] s_tdata,  // q_w[15:0], q_x[31:16], q_y[47:32], q_z[63:48]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata   // roll_angle[15:0], pitch_angle[30:16], yaw_angle[46:31]
);
	localparam int VW = qte_pkg::VEC_W;
	localparam int RW = qte_pkg::RND_W;
	localparam int N  = (CORDIC_STAGES < qte_pkg::ATAN_TAB_LEN) ?
	                    CORDIC_STAGES : qte_pkg::ATAN_TAB_LEN;
	localparam int SD = N + 2;

	logic                         en;
	logic                         t_valid, r_valid;
	qte_pkg::terms_t              terms, terms_d;
	logic [qte_pkg::REM_W-1:0]    rem;
	logic [qte_pkg::SQRT_W-1:0]   root;
	logic                         c_valid, c_valid_p, c_valid_y;
	logic signed [RW-1:0]         roll_a, pitch_a, yaw_a;
	logic [1:0]                   sat_dly_q [SD];
	logic signed [RW-1:0]         roll_c, pitch_c, yaw_c;
	logic [15:0]                  roll_q, yaw_q;
	logic [14:0]                  pitch_q;
	logic                         out_valid_q;

	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	qte_terms u_terms (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.q_w      (s_tdata[15:0]),
		.q_x      (s_tdata[31:16]),
		.q_y      (s_tdata[47:32]),
		.q_z      (s_tdata[63:48]),
		.out_valid(t_valid),
		.terms    (terms),
		.rem      (rem)
	);

	qte_isqrt #(
		.SIDE_W($bits(qte_pkg::terms_t))
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (t_valid),
		.rad      (rem),
		.side_in  (terms),
		.out_valid(r_valid),
		.root     (root),
		.side_out (terms_d)
	);

	qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(r_valid),
		.vy(VW'(terms_d.rs)), .vx(VW'(terms_d.rc)),
		.out_valid(c_valid), .angle(roll_a)
	);

	qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(r_valid),
		.vy(VW'(terms_d.ps)), .vx(VW'({1'b0, root})),
		.out_valid(c_valid_p), .angle(pitch_a)
	);

	qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(r_valid),
		.vy(VW'(terms_d.ys)), .vx(VW'(terms_d.yc)),
		.out_valid(c_valid_y), .angle(yaw_a)
	);

	// Saturation flags follow the pitch item through the CORDIC stages.
	always_ff @(posedge clk) begin
		if (en) begin
			sat_dly_q[0] <= {terms_d.sat_neg, terms_d.sat_pos};
			for (int k = 1; k < SD; k++) begin
				sat_dly_q[k] <= sat_dly_q[k-1];
			end
		end
	end

	always_comb begin
		roll_c = roll_a;
		if (roll_a > qte_pkg::HALF_LIM) roll_c = qte_pkg::HALF_LIM;
		if (roll_a < -qte_pkg::HALF_LIM) roll_c = -qte_pkg::HALF_LIM;
		yaw_c = yaw_a;
		if (yaw_a > qte_pkg::HALF_LIM) yaw_c = qte_pkg::HALF_LIM;
		if (yaw_a < -qte_pkg::HALF_LIM) yaw_c = -qte_pkg::HALF_LIM;
		pitch_c = pitch_a;
		if (pitch_a > qte_pkg::QUARTER_LIM) pitch_c = qte_pkg::QUARTER_LIM;
		if (pitch_a < -qte_pkg::QUARTER_LIM) pitch_c = -qte_pkg::QUARTER_LIM;
		if (sat_dly_q[SD-1][0]) pitch_c = qte_pkg::QUARTER_LIM;
		if (sat_dly_q[SD-1][1]) pitch_c = -qte_pkg::QUARTER_LIM;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= c_valid && c_valid_p && c_valid_y;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_q  <= roll_c[15:0];
			pitch_q <= pitch_c[14:0];
			yaw_q   <= yaw_c[15:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, yaw_q, pitch_q, roll_q};
endmodule
`default_nettype wire

/* tb/sv/tb_quaternion_to_euler_degrees.sv */
// Self-checking testbench for the quaternion to Euler angle converter.
`timescale 1ns / 1ps
`default_nettype none
module tb_quaternion_to_euler_degrees;

	localparam int STAGES    = 16;
	localparam int LATENCY   = 51;
	localparam int CYCLE_CAP = 400000;
	localparam longint ONE_Q28 = 64'sd1 << 28;

	// Listed from the top bit down, so roll sits in the lowest bits.
	typedef struct packed {
		logic signed [15:0] yaw;
		logic signed [14:0] pitch;
		logic signed [15:0] roll;
	} euler_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;

	euler_t angles_due[$];
	int     errors;
	longint cycles;
	int     out_wait;

	quaternion_to_euler_degrees #(.CORDIC_STAGES(STAGES)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint isqrt(longint unsigned v);
		longint unsigned op, res, bitv;
		op = v;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > op) bitv >>= 2;
		while (bitv != 0) begin
			if (op >= res + bitv) begin
				op -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint atan_deg(int i);
		longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
		return tab[i];
	endfunction

	// Vectoring arctangent in 1/65536 degree.
	function automatic longint vector_angle(longint yy, longint xx);
		longint ang, nx, ny, dx, dy;
		ang = 0;
		if (xx == 0 && yy == 0) return 0;
		if (xx < 0) begin
			if (yy >= 0) begin
				nx = yy; ny = -xx; ang = 90 * 65536;
			end else begin
				nx = -yy; ny = xx; ang = -90 * 65536;
			end
			xx = nx; yy = ny;
		end
		for (int i = 0; i < STAGES && i < 24; i++) begin
			dx = floor_shift(yy, i);
			dy = floor_shift(xx, i);
			if (yy >= 0) begin
				xx += dx; yy -= dy; ang += atan_deg(i);
			end else begin
				xx -= dx; yy += dy; ang -= atan_deg(i);
			end
		end
		return ang;
	endfunction

	function automatic longint to_units(longint ang, longint lim);
		longint a;
		a = floor_shift(ang + 256, 9);
		if (a > lim) a = lim;
		if (a < -lim) a = -lim;
		return a;
	endfunction

	function automatic euler_t predict_angles(logic [63:0] q);
		longint w, x, y, z, ps, mag;
		longint unsigned rem;
		euler_t e;
		w = longint'($signed(q[15:0]));
		x = longint'($signed(q[31:16]));
		y = longint'($signed(q[47:32]));
		z = longint'($signed(q[63:48]));
		e.roll = 16'(to_units(vector_angle(2 * (w * x + y * z),
			ONE_Q28 - 2 * (x * x + y * y)), 23040));
		ps = 2 * (w * y - z * x);
		if (ps >= ONE_Q28) e.pitch = 15'sd11520;
		else if (ps <= -ONE_Q28) e.pitch = -15'sd11520;
		else begin
			mag = ps < 0 ? -ps : ps;
			rem = (64'd1 << 56) - longint'(mag * mag);
			e.pitch = 15'(to_units(vector_angle(ps, isqrt(rem)), 11520));
		end
		e.yaw = 16'(to_units(vector_angle(2 * (w * z + x * y),
			ONE_Q28 - 2 * (y * y + z * z)), 23040));
		return e;
	endfunction

	// The valid line is only dropped when a gap follows, so back to back requests
	// never see two assignments in one time step.
	task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
		logic [15:0] z);
		int gap;
		gap = $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {z, y, x, w};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		angles_due.push_back(predict_angles({z, y, x, w}));
	endtask

	// Result side: compare each result, then wait a drawn number of idle cycles.
	always @(posedge clk) begin
		euler_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[46:0];
				if (angles_due.size() == 0) begin
					$display("%0t: unexpected result %h", $time, m_tdata);
					errors++;
				end else begin
					want = angles_due.pop_front();
					if (got.roll !== want.roll) begin
						$display("%0t: roll expected %0d actual %0d", $time, want.roll, got.roll);
						errors++;
					end
					if (got.pitch !== want.pitch) begin
						$display("%0t: pitch expected %0d actual %0d", $time, want.pitch,
							got.pitch);
						errors++;
					end
					if (got.yaw !== want.yaw) begin
						$display("%0t: yaw expected %0d actual %0d", $time, want.yaw, got.yaw);
						errors++;
					end
				end
				out_wait = $urandom_range(0, 5);
			end else if (out_wait > 0) begin
				out_wait--;
			end
			m_tready <= (out_wait == 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic test_extremes;
		logic [15:0] v[6] = '{16'sd16384, -16'sd16384, 16'sd0, 16'sd1, 16'h7FFF, 16'h8000};
		send_quat(16'd16384, 0, 0, 0);
		send_quat(0, 16'd16384, 0, 0);
		send_quat(0, 0, 16'd16384, 0);
		send_quat(0, 0, 0, 16'd16384);
		send_quat(0, 0, 0, 0);
		for (int i = 0; i < 6; i++) send_quat(v[i], v[(i + 1) % 6], v[(i + 2) % 6], v[i]);
		send_quat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
	endtask

	task automatic test_pitch_saturation;
		// Gimbal lock at either pole, and just short of it.
		send_quat(16'd11585, 0, 16'd11585, 0);
		send_quat(16'd11585, 0, -16'sd11585, 0);
		send_quat(16'd11586, 0, 16'd11586, 0);
		send_quat(16'd11585, 16'd11585, 16'd11585, -16'sd11585);
		send_quat(16'd11584, 0, 16'd11584, 0);
		send_quat(16'd11584, 0, -16'sd11584, 0);
	endtask

	task automatic test_negative_axis;
		// Cosine terms negative with zero sine give a half turn.
		send_quat(0, 16'd16384, 0, 16'd0);
		send_quat(0, 0, 16'd16384, 0);
		send_quat(0, -16'sd16384, 0, 0);
		send_quat(16'd100, 16'd16000, 0, 0);
		send_quat(-16'sd100, 16'd16000, 0, 0);
	endtask

	task automatic test_random;
		int r;
		for (int n = 0; n < 600; n++) begin
			r = $urandom_range(0, 9);
			if (r < 7) begin
				// Random quaternion, each component drawn within plus or minus one in Q1.14.
				send_quat(16'($signed($urandom_range(0, 32768)) - 16384),
					16'($signed($urandom_range(0, 32768)) - 16384),
					16'($signed($urandom_range(0, 32768)) - 16384),
					16'($signed($urandom_range(0, 32768)) - 16384));
			end else begin
				send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin
		errors   = 0;
		cycles   = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes;
		test_pitch_saturation;
		test_negative_axis;
		test_random;
		s_tvalid <= 1'b0;
		while (angles_due.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && angles_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
rtl/core/qte_pkg.sv
rtl/core/qte_terms.sv
rtl/core/qte_isqrt.sv
rtl/core/qte_cordic.sv
rtl/core/quaternion_to_euler_degrees.sv
tb/sv/tb_quaternion_to_euler_degrees.sv
